@@ hdl/seas_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the SPI EEPROM sequencer.
`timescale 1ns / 1ps

package seas_pkg;

	// Longest page data burst the link side supports.
	localparam int SEND_LIMIT = 32;
	localparam int SEND_W     = $clog2(SEND_LIMIT + 1);

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BITS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BYTES    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_OPCODE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_OPCODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OPCODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_OPCODE = 3'd5;

	// Configuration reset values.
	localparam logic [4:0] ADDRESS_BITS_RESET  = 5'd16;
	localparam logic [5:0] PAGE_BYTES_RESET    = 6'd16;
	localparam logic [7:0] READ_OPCODE_RESET   = 8'h03;
	localparam logic [7:0] WRITE_OPCODE_RESET  = 8'h02;
	localparam logic [7:0] STATUS_OPCODE_RESET = 8'h05;
	localparam logic [7:0] ENABLE_OPCODE_RESET = 8'h06;

	// Host and link command codes.
	localparam logic [2:0] CMD_READ       = 3'd0;
	localparam logic [2:0] CMD_WRITE      = 3'd1;
	localparam logic [2:0] CMD_LOAD       = 3'd2;
	localparam logic [2:0] CMD_PAGE_WRITE = 3'd3;
	localparam logic [2:0] CMD_LINK_BYTE  = 3'd4;
	localparam logic [2:0] CMD_LINK_ERR   = 3'd5;

	// Result kind codes.
	localparam logic [2:0] KIND_SEND     = 3'd0;
	localparam logic [2:0] KIND_RECV     = 3'd1;
	localparam logic [2:0] KIND_RDATA    = 3'd2;
	localparam logic [2:0] KIND_DONE     = 3'd3;
	localparam logic [2:0] KIND_LINK_ERR = 3'd4;
	localparam logic [2:0] KIND_REJECT   = 3'd5;

	// Address width thresholds.
	localparam logic [4:0] ADDR_BITS_NINE    = 5'd9;
	localparam logic [4:0] ADDR_BITS_TWO_MIN = 5'd10;
	localparam logic [4:0] ADDR_BITS_TWO_MAX = 5'd16;

	// Opcode and status bit patterns.
	localparam logic [7:0]  OP_HI_ADDR_BIT    = 8'h08;
	localparam logic [23:0] ADDR_ONE_BYTE_MAX = 24'h0000FF;
	localparam logic [7:0]  STATUS_WEL_ONLY   = 8'h02;
	localparam logic [7:0]  STATUS_BUSY_MASK  = 8'h01;

	// Source of the byte placed in a result.
	typedef enum logic [3:0] {
		SEL_ZERO,
		SEL_RD_OP,
		SEL_WR_OP,
		SEL_ADDR_HI,
		SEL_ADDR_MID,
		SEL_ADDR_LO,
		SEL_ST_OP,
		SEL_EN_OP,
		SEL_PEND,
		SEL_PAGE,
		SEL_RX
	} byte_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       commit_addr;
		logic       commit_data;
		logic       store_wr;
		logic       load_clr;
		logic       page_clr;
		logic       page_rd;
		logic       page_inc;
		logic       emit;
		logic [2:0] kind;
		byte_sel_t  sel;
		logic       end_frame;
		logic       last;
		logic       hdr_wr;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] cmd;
		logic       rx_wel_ok;
		logic       rx_busy;
		logic       addr_three;
		logic       addr_two;
		logic       page_empty;
		logic       page_last;
		logic       out_free;
	} dp_sts_t;

endpackage

@@ hdl/spi_eeprom_access_sequencer.sv @@
// Top level of the SPI EEPROM access sequencer: controller, datapath and checks.
//
//   channel   signals                                   direction
//   in        in_valid/in_ready, command/address/data   host and link -> block
//   out       out_valid/out_ready, kind/byte/end/last   block -> link and host
//   cfg       cfg_we, cfg_index, cfg_data               host -> block, write only
//
// An accepted item is decoded in the cycle after its transfer; each result is then
// registered in the output register, and each page data byte is first read through
// the page store read port, which is registered. The next item is taken only once
// the current one has put out all its results.
// Reset clears the page store through per-entry valid bits; there is no clearing pass.
// A stalled output register holds the sequence in place without losing a result.
`timescale 1ns / 1ps

module spi_eeprom_access_sequencer #(
	parameter int PAGE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [seas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [seas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      command,
	input  logic [23:0]                     address,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      kind,
	output logic [7:0]                      byte_value,
	output logic                            end_frame,
	output logic                            last
);
	import seas_pkg::*;

	dp_cmd_t ctl;
	dp_sts_t sts;

	// Sequencing control.
	seas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// Registers, page store and result register.
	seas_dp #(
		.PAGE_DEPTH (PAGE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.command    (command),
		.address    (address),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.byte_value (byte_value),
		.end_frame  (end_frame),
		.last       (last),
		.ctl        (ctl),
		.sts        (sts)
	);

`ifndef SYNTHESIS
	// After an input transfer the block is busy decoding it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while the previous item was still being decoded");

	// Chip select is released only by link actions.
	a_end_on_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_frame |-> (kind == KIND_SEND || kind == KIND_RECV))
		else $error("end of frame on a result that is not a link action");

	// Only sends and read data carry a byte.
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_SEND && kind != KIND_RDATA |-> byte_value == 8'h00)
		else $error("nonzero byte on a result that carries none");
`endif

endmodule

@@ hdl/seas_dp.sv @@
// Datapath of the SPI EEPROM sequencer: configuration, item latches, page store and result register.
`timescale 1ns / 1ps

module seas_dp #(
	parameter int PAGE_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [seas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [seas_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [2:0]                      command,
	input  logic [23:0]                     address,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      kind,
	output logic [7:0]                      byte_value,
	output logic                            end_frame,
	output logic                            last,
	input  seas_pkg::dp_cmd_t               ctl,
	output seas_pkg::dp_sts_t               sts
);
	import seas_pkg::*;

	localparam int AW       = $clog2(PAGE_DEPTH);
	localparam int SEND_MAX = (PAGE_DEPTH < SEND_LIMIT) ? PAGE_DEPTH : SEND_LIMIT;
	localparam logic [AW-1:0]     LOAD_LAST  = AW'(PAGE_DEPTH - 1);
	localparam logic [SEND_W-1:0] SEND_MAX_V = SEND_W'(SEND_MAX);

	logic [4:0]  addr_width_q;
	logic [5:0]  page_bytes_q;
	logic [7:0]  read_op_q;
	logic [7:0]  write_op_q;
	logic [7:0]  status_op_q;
	logic [7:0]  enable_op_q;

	logic [2:0]  cur_cmd_q;
	logic [23:0] cur_addr_q;
	logic [7:0]  cur_data_q;
	logic [23:0] pend_addr_q;
	logic [7:0]  pend_data_q;

	logic [7:0]            mem [PAGE_DEPTH];
	logic [PAGE_DEPTH-1:0] valid_q;
	logic [7:0]            rd_data_q;
	logic                  rd_valid_q;
	logic [AW-1:0]         load_q;
	logic [SEND_W-1:0]     idx_q;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [7:0]  byte_q;
	logic        end_q;
	logic        last_q;

	logic [23:0]       hdr_addr;
	logic [7:0]        hdr_op;
	logic [7:0]        byte_nxt;
	logic [SEND_W-1:0] send_cnt;

	// Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_width_q <= ADDRESS_BITS_RESET;
			page_bytes_q <= PAGE_BYTES_RESET;
			read_op_q    <= READ_OPCODE_RESET;
			write_op_q   <= WRITE_OPCODE_RESET;
			status_op_q  <= STATUS_OPCODE_RESET;
			enable_op_q  <= ENABLE_OPCODE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ADDRESS_BITS:  addr_width_q <= cfg_data[4:0];
				CFG_PAGE_BYTES:    page_bytes_q <= cfg_data[5:0];
				CFG_READ_OPCODE:   read_op_q    <= cfg_data;
				CFG_WRITE_OPCODE:  write_op_q   <= cfg_data;
				CFG_STATUS_OPCODE: status_op_q  <= cfg_data;
				CFG_ENABLE_OPCODE: enable_op_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Latch of the accepted item and of the pending write request.
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cur_cmd_q  <= command;
			cur_addr_q <= address;
			cur_data_q <= data_byte;
		end
		if (ctl.commit_addr) begin
			pend_addr_q <= cur_addr_q;
		end
		if (ctl.commit_data) begin
			pend_data_q <= cur_data_q;
		end
	end

	// Page store write port.
	always_ff @(posedge clk) begin
		if (ctl.store_wr) begin
			mem[load_q] <= cur_data_q;
		end
	end

	// Page store read port, registered.
	always_ff @(posedge clk) begin
		if (ctl.page_rd) begin
			rd_data_q <= mem[AW'(idx_q)];
		end
	end

	// Entry valid bits, load pointer and send index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			load_q     <= '0;
			idx_q      <= '0;
		end else begin
			if (ctl.store_wr) begin
				valid_q[load_q] <= 1'b1;
				load_q <= (load_q == LOAD_LAST) ? '0 : load_q + 1'b1;
			end else if (ctl.load_clr) begin
				load_q <= '0;
			end
			if (ctl.page_rd) begin
				rd_valid_q <= valid_q[AW'(idx_q)];
			end
			if (ctl.page_clr) begin
				idx_q <= '0;
			end else if (ctl.page_inc) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Header opcode with the high address bit folded in for nine-bit parts.
	always_comb begin
		hdr_addr = ctl.hdr_wr ? pend_addr_q : cur_addr_q;
		hdr_op   = ctl.hdr_wr ? write_op_q : read_op_q;
		if (addr_width_q == ADDR_BITS_NINE && hdr_addr > ADDR_ONE_BYTE_MAX) begin
			hdr_op = hdr_op | OP_HI_ADDR_BIT;
		end
	end

	// Byte selection for the next result.
	always_comb begin
		unique case (ctl.sel)
			SEL_ZERO:     byte_nxt = '0;
			SEL_RD_OP:    byte_nxt = hdr_op;
			SEL_WR_OP:    byte_nxt = hdr_op;
			SEL_ADDR_HI:  byte_nxt = hdr_addr[23:16];
			SEL_ADDR_MID: byte_nxt = hdr_addr[15:8];
			SEL_ADDR_LO:  byte_nxt = hdr_addr[7:0];
			SEL_ST_OP:    byte_nxt = status_op_q;
			SEL_EN_OP:    byte_nxt = enable_op_q;
			SEL_PEND:     byte_nxt = pend_data_q;
			SEL_PAGE:     byte_nxt = rd_valid_q ? rd_data_q : 8'h00;
			SEL_RX:       byte_nxt = cur_data_q;
			default:      byte_nxt = '0;
		endcase
	end

	// Result register: holds one result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			kind_q <= ctl.kind;
			byte_q <= byte_nxt;
			end_q  <= ctl.end_frame;
			last_q <= ctl.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign byte_value = byte_q;
	assign end_frame  = end_q;
	assign last       = last_q;

	// Status toward the controller.
	assign send_cnt = (SEND_W'(page_bytes_q) > SEND_MAX_V) ? SEND_MAX_V : SEND_W'(page_bytes_q);

	always_comb begin
		sts            = '0;
		sts.cmd        = cur_cmd_q;
		sts.rx_wel_ok  = (cur_data_q == STATUS_WEL_ONLY);
		sts.rx_busy    = ((cur_data_q & STATUS_BUSY_MASK) != 8'h00);
		sts.addr_three = (addr_width_q > ADDR_BITS_TWO_MAX);
		sts.addr_two   = (addr_width_q >= ADDR_BITS_TWO_MIN);
		sts.page_empty = (send_cnt == '0);
		sts.page_last  = (({1'b0, idx_q} + 1'b1) == {1'b0, send_cnt});
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

@@ hdl/seas_ctrl.sv @@
// Controller state machine of the SPI EEPROM sequencer.
`timescale 1ns / 1ps

module seas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output seas_pkg::dp_cmd_t ctl,
	input  seas_pkg::dp_sts_t sts
);
	import seas_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_OP,
		S_ADDR_HI,
		S_ADDR_MID,
		S_ADDR_LO,
		S_ENABLE,
		S_STATUS,
		S_RECV,
		S_DATA,
		S_PAGE_RD,
		S_PAGE_TX,
		S_SINGLE
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_ENABLE,
		PH_BUSY
	} phase_t;

	state_t     state_q;
	phase_t     phase_q;
	logic       is_page_q;
	logic       hdr_wr_q;
	logic [2:0] single_kind_q;

	logic go;
	logic busy_req;

	assign in_ready = (state_q == S_IDLE);
	assign go       = sts.out_free;
	assign busy_req = (sts.cmd <= CMD_PAGE_WRITE) && (phase_q != PH_IDLE);

	// Sequencing, request phase and per-request flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_IDLE;
			is_page_q     <= 1'b0;
			hdr_wr_q      <= 1'b0;
			single_kind_q <= KIND_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (busy_req) begin
						single_kind_q <= KIND_REJECT;
						state_q       <= S_SINGLE;
					end else begin
						unique case (sts.cmd)
							CMD_READ: begin
								hdr_wr_q <= 1'b0;
								phase_q  <= PH_READ;
								state_q  <= S_OP;
							end
							CMD_WRITE: begin
								is_page_q <= 1'b0;
								phase_q   <= PH_ENABLE;
								state_q   <= S_ENABLE;
							end
							CMD_LOAD: begin
								single_kind_q <= KIND_DONE;
								state_q       <= S_SINGLE;
							end
							CMD_PAGE_WRITE: begin
								is_page_q <= 1'b1;
								phase_q   <= PH_ENABLE;
								state_q   <= S_ENABLE;
							end
							CMD_LINK_BYTE: begin
								unique case (phase_q)
									PH_IDLE: state_q <= S_IDLE;
									PH_READ: begin
										single_kind_q <= KIND_RDATA;
										phase_q       <= PH_IDLE;
										state_q       <= S_SINGLE;
									end
									PH_ENABLE: begin
										if (sts.rx_wel_ok) begin
											hdr_wr_q <= 1'b1;
											phase_q  <= PH_BUSY;
											state_q  <= S_OP;
										end else begin
											state_q <= S_ENABLE;
										end
									end
									PH_BUSY: begin
										if (!sts.rx_busy) begin
											single_kind_q <= KIND_DONE;
											phase_q       <= PH_IDLE;
											state_q       <= S_SINGLE;
										end else begin
											state_q <= S_STATUS;
										end
									end
								endcase
							end
							CMD_LINK_ERR: begin
								single_kind_q <= KIND_LINK_ERR;
								phase_q       <= PH_IDLE;
								state_q       <= S_SINGLE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_OP: begin
					if (go) begin
						if (sts.addr_three) begin
							state_q <= S_ADDR_HI;
						end else if (sts.addr_two) begin
							state_q <= S_ADDR_MID;
						end else begin
							state_q <= S_ADDR_LO;
						end
					end
				end
				S_ADDR_HI: begin
					if (go) begin
						state_q <= S_ADDR_MID;
					end
				end
				S_ADDR_MID: begin
					if (go) begin
						state_q <= S_ADDR_LO;
					end
				end
				S_ADDR_LO: begin
					if (go) begin
						priority if (!hdr_wr_q) begin
							state_q <= S_RECV;
						end else if (!is_page_q) begin
							state_q <= S_DATA;
						end else if (sts.page_empty) begin
							state_q <= S_STATUS;
						end else begin
							state_q <= S_PAGE_RD;
						end
					end
				end
				S_ENABLE: begin
					if (go) begin
						state_q <= S_STATUS;
					end
				end
				S_STATUS: begin
					if (go) begin
						state_q <= S_RECV;
					end
				end
				S_RECV: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				S_DATA: begin
					if (go) begin
						state_q <= S_STATUS;
					end
				end
				S_PAGE_RD: begin
					state_q <= S_PAGE_TX;
				end
				S_PAGE_TX: begin
					if (go) begin
						state_q <= sts.page_last ? S_STATUS : S_PAGE_RD;
					end
				end
				S_SINGLE: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath commands decoded from the current state.
	always_comb begin
		ctl        = '0;
		ctl.sel    = SEL_ZERO;
		ctl.kind   = KIND_SEND;
		ctl.hdr_wr = hdr_wr_q;
		ctl.accept = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: ;
			S_DISPATCH: begin
				if (!busy_req) begin
					if (sts.cmd == CMD_WRITE) begin
						ctl.commit_addr = 1'b1;
						ctl.commit_data = 1'b1;
					end
					if (sts.cmd == CMD_PAGE_WRITE) begin
						ctl.commit_addr = 1'b1;
						ctl.load_clr    = 1'b1;
					end
					if (sts.cmd == CMD_LOAD) begin
						ctl.store_wr = 1'b1;
					end
					if (sts.cmd == CMD_LINK_BYTE && phase_q == PH_ENABLE && sts.rx_wel_ok) begin
						ctl.page_clr = 1'b1;
					end
				end
			end
			S_OP: begin
				ctl.emit = go;
				ctl.sel  = hdr_wr_q ? SEL_WR_OP : SEL_RD_OP;
			end
			S_ADDR_HI: begin
				ctl.emit = go;
				ctl.sel  = SEL_ADDR_HI;
			end
			S_ADDR_MID: begin
				ctl.emit = go;
				ctl.sel  = SEL_ADDR_MID;
			end
			S_ADDR_LO: begin
				ctl.emit      = go;
				ctl.sel       = SEL_ADDR_LO;
				ctl.end_frame = hdr_wr_q && is_page_q && sts.page_empty;
			end
			S_ENABLE: begin
				ctl.emit      = go;
				ctl.sel       = SEL_EN_OP;
				ctl.end_frame = 1'b1;
			end
			S_STATUS: begin
				ctl.emit = go;
				ctl.sel  = SEL_ST_OP;
			end
			S_RECV: begin
				ctl.emit      = go;
				ctl.kind      = KIND_RECV;
				ctl.end_frame = 1'b1;
				ctl.last      = 1'b1;
			end
			S_DATA: begin
				ctl.emit      = go;
				ctl.sel       = SEL_PEND;
				ctl.end_frame = 1'b1;
			end
			S_PAGE_RD: begin
				ctl.page_rd = 1'b1;
			end
			S_PAGE_TX: begin
				ctl.emit      = go;
				ctl.page_inc  = go;
				ctl.sel       = SEL_PAGE;
				ctl.end_frame = sts.page_last;
			end
			S_SINGLE: begin
				ctl.emit = go;
				ctl.kind = single_kind_q;
				ctl.sel  = (single_kind_q == KIND_RDATA) ? SEL_RX : SEL_ZERO;
				ctl.last = 1'b1;
			end
		endcase
	end

endmodule
